// ===== hw/rtl/sssd_pkg.sv =====
package sssd_pkg;

	// Default operand width
	localparam int DATA_WIDTH_DEF = 32;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SAT     = 2'd1,
		ST_DIVZERO = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		CTL_IDLE = 2'd0,
		CTL_CALC = 2'd1,
		CTL_DONE = 2'd2
	} ctl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture operand magnitudes and signs
		logic step;    // one shift-and-subtract iteration
		logic finish;  // apply sign, saturate, load the result register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_zero;  // captured divisor is zero
	} dp_stat_t;

endpackage

// ===== hw/rtl/sssd_datapath.sv =====
module sssd_datapath
	import sssd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	input  dp_cmd_t                      cmd,
	output dp_stat_t                     stat,
	output logic signed [DATA_WIDTH-1:0] quotient,
	output status_t                      status
);

	localparam logic [DATA_WIDTH-1:0] ONE     = DATA_WIDTH'(1);
	localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	logic [DATA_WIDTH-1:0] acc_q;   // dividend bits shift out, quotient bits shift in
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] div_q;
	logic                  neg_q;
	logic                  zero_q;
	logic [DATA_WIDTH-1:0] quo_q;
	status_t               status_q;

	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic [DATA_WIDTH-1:0] shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;

	always_comb begin
		a_mag = dividend[DATA_WIDTH-1] ? (~dividend) + ONE : dividend;
		b_mag = divisor[DATA_WIDTH-1] ? (~divisor) + ONE : divisor;
		// Remainder stays below the divisor, so its top bit is always clear.
		shifted = {rem_q[DATA_WIDTH-2:0], acc_q[DATA_WIDTH-1]};
		diff    = {1'b0, shifted} - {1'b0, div_q};
		ge      = ~diff[DATA_WIDTH];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q  <= a_mag;
			rem_q  <= '0;
			div_q  <= b_mag;
			neg_q  <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
			zero_q <= (divisor == '0);
		end else if (cmd.step) begin
			rem_q <= ge ? diff[DATA_WIDTH-1:0] : shifted;
			acc_q <= {acc_q[DATA_WIDTH-2:0], ge};
		end
	end

	// Sign and saturation; a set top bit means magnitude 2^(W-1), which
	// negates to itself and saturates only when the result is positive.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (zero_q) begin
				quo_q    <= '0;
				status_q <= ST_DIVZERO;
			end else if (neg_q) begin
				quo_q    <= (~acc_q) + ONE;
				status_q <= ST_OK;
			end else if (acc_q[DATA_WIDTH-1]) begin
				quo_q    <= MAX_POS;
				status_q <= ST_SAT;
			end else begin
				quo_q    <= acc_q;
				status_q <= ST_OK;
			end
		end
	end

	assign stat.div_zero = zero_q;
	assign quotient      = $signed(quo_q);
	assign status        = status_q;

endmodule

// ===== hw/rtl/sssd_ctrl.sv =====
module sssd_ctrl
	import sssd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	ctl_state_t       state_q;
	ctl_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             out_valid_q;
	logic             out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q & ~m_tready;
		s_tready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			CTL_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = CNT_W'(DATA_WIDTH - 1);
					state_d  = CTL_CALC;
				end
			end
			CTL_CALC: begin
				// Skip the iterations when the divisor is zero.
				if (stat.div_zero) begin
					state_d = CTL_DONE;
				end else begin
					cmd.step = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_d = CTL_DONE;
					end
				end
			end
			CTL_DONE: begin
				// Hold until the result register is free.
				if (!out_valid_q || m_tready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== hw/rtl/signed_shift_subtract_divider_top.sv =====
// Channel | Dir | Signals                    | Item
// --------+-----+----------------------------+-------------------------------------------
// s_*     | in  | s_tvalid s_tready s_tdata  | dividend, divisor (signed, DATA_WIDTH each)
// m_*     | out | m_tvalid m_tready m_tdata  | quotient (signed DATA_WIDTH)
//         |     | m_tuser                    | status: 0 ok, 1 saturated, 2 divisor zero
//
// Each item first has its operand magnitudes captured, then runs one
// iteration per quotient bit in the shared shift-and-subtract unit, then
// has the sign applied and the result register filled.
// A zero divisor skips the iterations and goes on to fill the result register.
// One item is in flight at a time; the next one is taken while the result
// still waits in the output register. A stalled result holds the finish step.
// arst_n clears the controller and the result valid flag; data needs no reset.
module signed_shift_subtract_divider_top
	import sssd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// dividend [DATA_WIDTH-1:0], divisor [2*DATA_WIDTH-1:DATA_WIDTH], zero pad above
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// quotient [DATA_WIDTH-1:0], zero pad above
	output logic [((DATA_WIDTH+7)/8)*8-1:0]           m_tdata,
	// status [1:0]
	output logic [1:0]                                m_tuser
);

	localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

	dp_cmd_t                      cmd;
	dp_stat_t                     stat;
	logic signed [DATA_WIDTH-1:0] dividend;
	logic signed [DATA_WIDTH-1:0] divisor;
	logic signed [DATA_WIDTH-1:0] quotient;
	status_t                      status;

	// Unpack the operands; pad bits are dropped.
	assign dividend = $signed(s_tdata[DATA_WIDTH-1:0]);
	assign divisor  = $signed(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);

	sssd_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	sssd_datapath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk      (clk),
		.dividend (dividend),
		.divisor  (divisor),
		.cmd      (cmd),
		.stat     (stat),
		.quotient (quotient),
		.status   (status)
	);

	// Zero-extend the quotient to whole bytes.
	assign m_tdata = M_TDATA_W'($unsigned(quotient));
	assign m_tuser = status;

`ifndef ASSERT_OFF
	// One item at a time: after an accept, input is held off.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// A zero divisor always yields a zero quotient.
	a_divzero_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_DIVZERO |-> quotient == '0)
		else $error("nonzero quotient on zero divisor");

	// Saturation only ever produces the largest positive value.
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_SAT |-> quotient == {1'b0, {(DATA_WIDTH-1){1'b1}}})
		else $error("saturated quotient is not the maximum");

	// Status code 3 is never produced.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("undefined status code");
`endif

endmodule
